/* rtl/brl_pkg.sv */
package brl_pkg;

    localparam int COORD_WIDTH = 10;
    localparam int COLOR_WIDTH = 8;
    localparam int ERR_WIDTH   = COORD_WIDTH + 2;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_WIDTH  = $clog2(QUEUE_DEPTH);
    localparam int QCNT_WIDTH  = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [0:0] {
        OP_LOAD = 1'b0,
        OP_STEP = 1'b1
    } t_opcode;

    typedef struct packed {
        t_opcode                opcode;
        logic [COORD_WIDTH-1:0] start_x;
        logic [COORD_WIDTH-1:0] start_y;
        logic [COORD_WIDTH-1:0] end_x;
        logic [COORD_WIDTH-1:0] end_y;
        logic [COLOR_WIDTH-1:0] line_color;
    } t_in_item;

    typedef struct packed {
        logic [COORD_WIDTH-1:0] pixel_x;
        logic [COORD_WIDTH-1:0] pixel_y;
        logic [COLOR_WIDTH-1:0] pixel_color;
        logic                   last_pixel;
    } t_out_item;

    // Classified command as held in the queue between front and back
    typedef struct packed {
        t_opcode                opcode;
        logic                   steep;
        logic                   minor_down;
        logic [COORD_WIDTH-1:0] major_start;
        logic [COORD_WIDTH-1:0] minor_start;
        logic [COORD_WIDTH-1:0] major_end;
        logic [COORD_WIDTH-1:0] delta_major;
        logic [COORD_WIDTH-1:0] delta_minor;
        logic [COLOR_WIDTH-1:0] color;
    } t_cmd;

    typedef struct packed {
        logic busy;
        logic emit;
        logic emit_last;
    } t_back_stat;

endpackage

/* rtl/brl_front.sv */
module brl_front
    import brl_pkg::*;
(
    input  t_in_item i_item,
    output t_cmd     o_cmd
);

    logic [COORD_WIDTH-1:0] dx, dy;
    logic                   steep, swap;
    logic [COORD_WIDTH-1:0] a1, b1, a2, b2;
    logic [COORD_WIDTH-1:0] maj_s, min_s, maj_e, min_e;

    always_comb begin
        dx = (i_item.end_x >= i_item.start_x) ? (i_item.end_x - i_item.start_x)
                                              : (i_item.start_x - i_item.end_x);
        dy = (i_item.end_y >= i_item.start_y) ? (i_item.end_y - i_item.start_y)
                                              : (i_item.start_y - i_item.end_y);
        steep = dy > dx;

        a1 = steep ? i_item.start_y : i_item.start_x;
        b1 = steep ? i_item.start_x : i_item.start_y;
        a2 = steep ? i_item.end_y   : i_item.end_x;
        b2 = steep ? i_item.end_x   : i_item.end_y;

        // order so that the major axis increases; the deltas do not change
        swap  = a1 > a2;
        maj_s = swap ? a2 : a1;
        min_s = swap ? b2 : b1;
        maj_e = swap ? a1 : a2;
        min_e = swap ? b1 : b2;

        o_cmd.opcode      = i_item.opcode;
        o_cmd.steep       = steep;
        o_cmd.minor_down  = !(min_s < min_e);
        o_cmd.major_start = maj_s;
        o_cmd.minor_start = min_s;
        o_cmd.major_end   = maj_e;
        o_cmd.delta_major = steep ? dy : dx;
        o_cmd.delta_minor = steep ? dx : dy;
        o_cmd.color       = i_item.line_color;
    end

endmodule

/* rtl/brl_queue.sv */
module brl_queue
    import brl_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    output logic o_valid,
    input  logic i_pop,
    output t_cmd o_cmd
);

    t_cmd                  r_entries [QUEUE_DEPTH];
    logic [QPTR_WIDTH-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPTR_WIDTH-1:0] r_rd_ptr, n_rd_ptr;
    logic [QCNT_WIDTH-1:0] r_count, n_count;
    logic                  do_push, do_pop;

    assign o_full  = (r_count == QCNT_WIDTH'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_entries[r_rd_ptr];

    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == QPTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == QPTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        unique case ({do_push, do_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_entries[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

/* rtl/brl_back.sv */
module brl_back
    import brl_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  t_cmd       i_cmd,
    output logic       o_take,
    output logic       o_empty,
    input  logic       i_pop,
    output t_out_item  o_result,
    output t_back_stat o_stat
);

    logic                         r_busy, n_busy;
    logic                         r_steep, n_steep;
    logic                         r_minor_down, n_minor_down;
    logic [COORD_WIDTH-1:0]       r_major_pos, n_major_pos;
    logic [COORD_WIDTH-1:0]       r_minor_pos, n_minor_pos;
    logic [COORD_WIDTH-1:0]       r_major_end, n_major_end;
    logic [COORD_WIDTH-1:0]       r_delta_major, n_delta_major;
    logic [COORD_WIDTH-1:0]       r_delta_minor, n_delta_minor;
    logic signed [ERR_WIDTH-1:0]  r_error, n_error;
    logic [COLOR_WIDTH-1:0]       r_color, n_color;
    logic                         r_out_valid, n_out_valid;
    t_out_item                    r_out, n_out;

    logic                         is_load, discard, out_space, emit, last;
    logic signed [ERR_WIDTH-1:0]  cur_error, half, sum;

    assign is_load   = (i_cmd.opcode == OP_LOAD);
    assign discard   = i_valid && !is_load && !r_busy;
    assign out_space = !r_out_valid || i_pop;
    assign emit      = i_valid && !discard && out_space;
    assign o_take    = discard || emit;

    always_comb begin
        // a load starts from the queued command, a step from the held line
        n_steep       = is_load ? i_cmd.steep       : r_steep;
        n_minor_down  = is_load ? i_cmd.minor_down  : r_minor_down;
        n_major_end   = is_load ? i_cmd.major_end   : r_major_end;
        n_delta_major = is_load ? i_cmd.delta_major : r_delta_major;
        n_delta_minor = is_load ? i_cmd.delta_minor : r_delta_minor;
        n_color       = is_load ? i_cmd.color       : r_color;
        n_major_pos   = is_load ? i_cmd.major_start : r_major_pos;
        n_minor_pos   = is_load ? i_cmd.minor_start : r_minor_pos;

        half      = signed'({2'b00, 1'b0, i_cmd.delta_major[COORD_WIDTH-1:1]});
        cur_error = is_load ? -half : r_error;
        last      = (n_major_pos == n_major_end);

        n_out.pixel_x     = n_steep ? n_minor_pos : n_major_pos;
        n_out.pixel_y     = n_steep ? n_major_pos : n_minor_pos;
        n_out.pixel_color = n_color;
        n_out.last_pixel  = last;

        sum     = cur_error + signed'({2'b00, n_delta_minor});
        n_error = sum;
        if (!sum[ERR_WIDTH-1]) begin
            n_minor_pos = n_minor_down ? n_minor_pos - 1'b1 : n_minor_pos + 1'b1;
            n_error     = sum - signed'({2'b00, n_delta_major});
        end
        n_major_pos = n_major_pos + 1'b1;
        n_busy      = !last;

        n_out_valid = r_out_valid;
        if (emit) begin
            n_out_valid = 1'b1;
        end else if (i_pop) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (emit) begin
                r_busy <= n_busy;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_steep       <= n_steep;
            r_minor_down  <= n_minor_down;
            r_major_pos   <= n_major_pos;
            r_minor_pos   <= n_minor_pos;
            r_major_end   <= n_major_end;
            r_delta_major <= n_delta_major;
            r_delta_minor <= n_delta_minor;
            r_error       <= n_error;
            r_color       <= n_color;
            r_out         <= n_out;
        end
    end

    assign o_empty  = !r_out_valid;
    assign o_result = r_out;

    assign o_stat.busy      = r_busy;
    assign o_stat.emit      = emit;
    assign o_stat.emit_last = emit && last;

endmodule

/* rtl/bresenham_line_rasterizer_top.sv */
// Channel   Handshake          Payload     Direction
// items     i_push / o_full    i_item      in
// pixels    o_empty / i_pop    o_result    out
//
// One transaction per clock in each direction when neither side stalls: the
// back end's single add, compare and subtract per pixel sets the rate.
// A pixel appears on o_result in the cycle after its command leaves the queue;
// an accepted item is registered in the queue before it reaches the back end.
// Synchronous active-low reset clears the queue, the output valid flag and busy.
// A held pixel stalls the back end; the two-entry queue absorbs the front.
module bresenham_line_rasterizer_top
    import brl_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    output logic      o_full,
    input  t_in_item  i_item,
    output logic      o_empty,
    input  logic      i_pop,
    output t_out_item o_result
);

    t_cmd       front_cmd, queue_cmd;
    logic       queue_valid, queue_take;
    t_back_stat back_stat;

    brl_front u_front (
        .i_item (i_item),
        .o_cmd  (front_cmd)
    );

    brl_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_cmd   (front_cmd),
        .o_full  (o_full),
        .o_valid (queue_valid),
        .i_pop   (queue_take),
        .o_cmd   (queue_cmd)
    );

    brl_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (queue_valid),
        .i_cmd    (queue_cmd),
        .o_take   (queue_take),
        .o_empty  (o_empty),
        .i_pop    (i_pop),
        .o_result (o_result),
        .o_stat   (back_stat)
    );

    a_emit_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        back_stat.emit |=> !o_empty)
        else $error("emitted pixel not presented");

    a_last_idles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        back_stat.emit_last |=> !back_stat.busy)
        else $error("still busy after last pixel");

    a_full_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> queue_valid)
        else $error("queue full yet nothing offered to back end");

    a_push_seen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !o_full) |=> queue_valid)
        else $error("accepted transaction missing from queue");

endmodule

/* sim/bresenham_line_rasterizer_top_test.sv */
module bresenham_line_rasterizer_top_test;
    import brl_pkg::*;

    localparam int COORD_MAX       = (1 << COORD_WIDTH) - 1;
    localparam int ITEMS_PER_PHASE = 325;
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int RX_HOLD_CYCLES  = 300;

    logic      i_clk;
    logic      i_rst_n = 1'b0;
    logic      i_push  = 1'b0;
    logic      o_full;
    t_in_item  i_item  = '0;
    logic      o_empty;
    logic      i_pop   = 1'b0;
    t_out_item o_result;

    bresenham_line_rasterizer_top dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (i_push),
        .o_full   (o_full),
        .i_item   (i_item),
        .o_empty  (o_empty),
        .i_pop    (i_pop),
        .o_result (o_result)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    t_in_item  pending_items[$];
    t_out_item pixels_due[$];

    int send_idle_pct = 31;
    int recv_idle_pct = 58;
    int mismatches     = 0;
    int pixels_checked = 0;
    int loads_sent     = 0;
    int steps_sent     = 0;
    int full_stalls    = 0;
    int quiet_cycles   = 0;
    int rx_hold_left   = 0;
    bit rx_hold_used   = 1'b0;

    // Rasteriser state, mirrors the block
    bit                          ln_busy       = 1'b0;
    bit                          ln_steep      = 1'b0;
    bit                          ln_minor_down = 1'b0;
    logic [COORD_WIDTH-1:0]      ln_major      = '0;
    logic [COORD_WIDTH-1:0]      ln_minor      = '0;
    logic [COORD_WIDTH-1:0]      ln_major_end  = '0;
    logic [COORD_WIDTH-1:0]      ln_dmajor     = '0;
    logic [COORD_WIDTH-1:0]      ln_dminor     = '0;
    logic signed [ERR_WIDTH-1:0] ln_err        = '0;
    logic [COLOR_WIDTH-1:0]      ln_color      = '0;

    function automatic void rasterize(input t_in_item it);
        logic [COORD_WIDTH-1:0] a1, b1, a2, b2, swap, dx_abs, dy_abs;
        t_out_item px;
        if (it.opcode == OP_LOAD) begin
            dx_abs = (it.end_x > it.start_x) ? it.end_x - it.start_x : it.start_x - it.end_x;
            dy_abs = (it.end_y > it.start_y) ? it.end_y - it.start_y : it.start_y - it.end_y;
            ln_steep = dy_abs > dx_abs;
            if (ln_steep) begin
                a1 = it.start_y; b1 = it.start_x; a2 = it.end_y; b2 = it.end_x;
            end else begin
                a1 = it.start_x; b1 = it.start_y; a2 = it.end_x; b2 = it.end_y;
            end
            if (a1 > a2) begin
                swap = a1; a1 = a2; a2 = swap;
                swap = b1; b1 = b2; b2 = swap;
            end
            ln_dmajor     = a2 - a1;
            ln_dminor     = (b2 > b1) ? b2 - b1 : b1 - b2;
            ln_err        = -$signed({2'b00, ln_dmajor >> 1});
            ln_minor_down = !(b1 < b2);
            ln_major      = a1;
            ln_minor      = b1;
            ln_major_end  = a2;
            ln_color      = it.line_color;
        end else if (!ln_busy) begin
            return;
        end
        px.pixel_x     = ln_steep ? ln_minor : ln_major;
        px.pixel_y     = ln_steep ? ln_major : ln_minor;
        px.pixel_color = ln_color;
        px.last_pixel  = (ln_major == ln_major_end);
        pixels_due.push_back(px);
        ln_err = ln_err + $signed({2'b00, ln_dminor});
        if (ln_err >= 0) begin
            ln_minor = ln_minor_down ? ln_minor - 1'b1 : ln_minor + 1'b1;
            ln_err   = ln_err - $signed({2'b00, ln_dmajor});
        end
        ln_major = ln_major + 1'b1;
        ln_busy  = !px.last_pixel;
    endfunction

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= 32)
            $display("[%0t] pixel %0d: %s", $time, pixels_checked, what);
    endtask

    task automatic check_pixel(input t_out_item got);
        t_out_item want;
        if (pixels_due.size() == 0) begin
            report_mismatch($sformatf("unexpected pixel (%0d,%0d)", got.pixel_x, got.pixel_y));
            return;
        end
        want = pixels_due.pop_front();
        if (got.pixel_x !== want.pixel_x)
            report_mismatch($sformatf("x %0d, want %0d", got.pixel_x, want.pixel_x));
        if (got.pixel_y !== want.pixel_y)
            report_mismatch($sformatf("y %0d, want %0d", got.pixel_y, want.pixel_y));
        if (got.pixel_color !== want.pixel_color)
            report_mismatch($sformatf("colour %0h, want %0h", got.pixel_color, want.pixel_color));
        if (got.last_pixel !== want.last_pixel)
            report_mismatch($sformatf("last %0b, want %0b", got.last_pixel, want.last_pixel));
        pixels_checked++;
    endtask

    task automatic queue_steps(input int n);
        t_in_item    it;
        logic [63:0] raw;
        repeat (n) begin
            raw = {$urandom, $urandom};   // payload of a step is don't-care
            it = raw[$bits(t_in_item)-1:0];
            it.opcode = OP_STEP;
            pending_items.push_back(it);
        end
    endtask

    task automatic queue_line(input int x1, input int y1, input int x2, input int y2,
                              input int color, input int steps);
        t_in_item it;
        it.opcode     = OP_LOAD;
        it.start_x    = x1[COORD_WIDTH-1:0];
        it.start_y    = y1[COORD_WIDTH-1:0];
        it.end_x      = x2[COORD_WIDTH-1:0];
        it.end_y      = y2[COORD_WIDTH-1:0];
        it.line_color = color[COLOR_WIDTH-1:0];
        pending_items.push_back(it);
        queue_steps(steps);
    endtask

    function automatic int pick_coord();
        case ($urandom_range(7))
            0:       return 0;
            1:       return COORD_MAX;
            default: return $urandom_range(COORD_MAX);
        endcase
    endfunction

    function automatic int offset_coord(input int c, input int span);
        int v;
        v = int'($urandom_range(2 * span)) - span + c;
        if (v < 0)
            v = 0;
        if (v > COORD_MAX)
            v = COORD_MAX;
        return v;
    endfunction

    // Mostly whole short lines walked to the end (plus a stray step or two),
    // some cut short by the next load, a few long ones, and some raw noise.
    task automatic queue_random_lines(input int target);
        int useful, x1, y1, x2, y2, dx, dy, len, n, span;
        t_in_item    it;
        logic [63:0] raw;
        useful = 0;
        while (useful < target) begin
            if ($urandom_range(99) < 8) begin
                raw = {$urandom, $urandom};
                it = raw[$bits(t_in_item)-1:0];
                pending_items.push_back(it);
                useful++;
            end else begin
                span = ($urandom_range(99) < 85) ? 12 : COORD_MAX;
                x1 = pick_coord();
                y1 = pick_coord();
                x2 = offset_coord(x1, span);
                y2 = offset_coord(y1, span);
                dx = (x2 > x1) ? x2 - x1 : x1 - x2;
                dy = (y2 > y1) ? y2 - y1 : y1 - y2;
                len = (dx > dy) ? dx : dy;
                if ($urandom_range(3) != 0)
                    n = (len <= 40) ? len + $urandom_range(2) : $urandom_range(40);
                else
                    n = $urandom_range((len < 40) ? len : 40);
                queue_line(x1, y1, x2, y2, $urandom_range(255), n);
                useful += 1 + ((n < len) ? n : len);
            end
        end
    endtask

    task automatic wait_all_sent();
        while (pending_items.size() != 0 || i_push)
            @(negedge i_clk);
    endtask

    // Sender
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_push <= 1'b0;
        end else begin
            if (i_push && o_full)
                full_stalls++;
            if (i_push && !o_full) begin
                rasterize(i_item);
                if (i_item.opcode == OP_LOAD)
                    loads_sent++;
                else
                    steps_sent++;
            end
            if (!i_push || !o_full) begin
                if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    i_item <= pending_items.pop_front();
                    i_push <= 1'b1;
                end else begin
                    i_push <= 1'b0;
                end
            end
        end
    end

    // Receiver; one long hold-off partway through to back the block up
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_pop <= 1'b0;
        end else begin
            if (i_pop && !o_empty)
                check_pixel(o_result);
            if (rx_hold_left > 0) begin
                rx_hold_left <= rx_hold_left - 1;
                i_pop        <= 1'b0;
            end else if (!rx_hold_used && pixels_checked >= 200) begin
                rx_hold_used <= 1'b1;
                rx_hold_left <= RX_HOLD_CYCLES;
                i_pop        <= 1'b0;
            end else begin
                i_pop <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_push && !o_full) || (i_pop && !o_empty)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("no transaction for %0d cycles, %0d pixels outstanding",
                     quiet_cycles, pixels_due.size());
            $display("bresenham_line_rasterizer_top: mismatch");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        queue_steps(1);                                  // step with no line running
        queue_line(5, 5, 5, 5, 8'hFF, 1);                // single point, then idle step
        queue_line(0, 0, 3, 1, 8'h00, 4);                // shallow, walked past its end
        queue_line(10, 20, 8, 2, 8'h5A, 3);              // steep, reversed, cut by next load
        queue_line(COORD_MAX, COORD_MAX, 0, 0, 8'hA5, 1);
        queue_line(0, COORD_MAX, COORD_MAX, 0, 8'h3C, 1);
        queue_line(COORD_MAX, 0, COORD_MAX, COORD_MAX, 8'hC3, 1);
        queue_line(0, 7, COORD_MAX, 7, 8'h81, 1);
        queue_line(COORD_MAX - 3, COORD_MAX, COORD_MAX, COORD_MAX - 2, 8'h7E, 4);
        queue_random_lines(ITEMS_PER_PHASE);

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait_all_sent();

        send_idle_pct = 58;
        recv_idle_pct = 31;
        queue_random_lines(ITEMS_PER_PHASE);
        wait_all_sent();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        queue_random_lines(ITEMS_PER_PHASE);
        wait_all_sent();

        while (pixels_due.size() != 0)
            @(negedge i_clk);
        repeat (10) @(negedge i_clk);

        $display("%0d line loads and %0d steps sent, %0d pixels compared",
                 loads_sent, steps_sent, pixels_checked);
        $display("input held off by a full block on %0d cycles, %0d mismatches",
                 full_stalls, mismatches);
        if (mismatches == 0)
            $display("bresenham_line_rasterizer_top: match");
        else
            $display("bresenham_line_rasterizer_top: mismatch");
        $finish;
    end

endmodule

/* bresenham_line_rasterizer_top.f */
rtl/brl_pkg.sv
rtl/brl_front.sv
rtl/brl_queue.sv
rtl/brl_back.sv
rtl/bresenham_line_rasterizer_top.sv
sim/bresenham_line_rasterizer_top_test.sv
